[rtl/dahp_pkg.sv]
// Shared types, constants and helpers for the d-ary min-heap priority queue core.
package dahp_pkg;

   localparam int CAPACITY    = 256;
   localparam int MAX_ARITY   = 8;
   localparam int KEY_BITS    = 32;
   localparam int INFO_BITS   = 32;
   localparam int HANDLE_BITS = 8;
   localparam int COUNT_BITS  = 9;
   localparam int ARITY_BITS  = 4;
   localparam int INDEX_BITS  = 4;
   localparam int CHILD_BITS  = 12;
   localparam int RECIP_BITS  = 17;
   localparam int RECIP_SHIFT = 16;

   // operation kinds
   localparam logic [2:0] KIND_INSERT   = 3'd0;
   localparam logic [2:0] KIND_DECREASE = 3'd1;
   localparam logic [2:0] KIND_DELETE   = 3'd2;
   localparam logic [2:0] KIND_INFO     = 3'd3;
   localparam logic [2:0] KIND_CLEAR    = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_BAD_HDL  = 2'd2;
   localparam logic [1:0] STATUS_KEY_UP   = 2'd3;

   // register indexes
   localparam logic [INDEX_BITS-1:0] REG_ARITY = 4'd0;
   localparam logic [INDEX_BITS-1:0] REG_LIMIT = 4'd1;

   // one heap position: owning handle and its key
   typedef struct packed {
      logic [HANDLE_BITS-1:0] hdl;
      logic [KEY_BITS-1:0]    key;
   } entry_type;

   // operands for the shared index/compare unit
   typedef struct packed {
      logic [COUNT_BITS-1:0] pos;
      logic [ARITY_BITS-1:0] k;
      logic [KEY_BITS-1:0]   key_a;
      logic [KEY_BITS-1:0]   key_b;
   } alu_in_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] par;
      logic [CHILD_BITS-1:0] ci;
      logic [CHILD_BITS-1:0] last;
      logic                  a_gt_b;
   } alu_out_type;

   // ceil(2^16 / k); exact quotient for dividends below 256
   function automatic logic [RECIP_BITS-1:0] recip(input logic [ARITY_BITS-1:0] k);
      logic [RECIP_BITS-1:0] r;
      case (k)
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         default: r = 17'd32768;
      endcase
      return r;
   endfunction

endpackage

[rtl/dahp_alu.sv]
// Shared unit: parent index, first/last child index and signed key compare.
module dahp_alu (
   input  dahp_pkg::alu_in_type  alu_i,
   output dahp_pkg::alu_out_type alu_o
);
   import dahp_pkg::*;

   logic [HANDLE_BITS-1:0]             x;
   logic [HANDLE_BITS+RECIP_BITS-1:0]  prod;
   logic [HANDLE_BITS-1:0]             pm1;
   logic [CHILD_BITS-1:0]              ci;

   // parent = (pos - 2) / k + 1, via reciprocal multiply
   assign x    = HANDLE_BITS'(alu_i.pos - COUNT_BITS'(2));
   assign prod = (HANDLE_BITS+RECIP_BITS)'(x) * (HANDLE_BITS+RECIP_BITS)'(recip(alu_i.k));
   assign alu_o.par = COUNT_BITS'(prod[RECIP_SHIFT +: HANDLE_BITS]) + COUNT_BITS'(1);

   // first child = (pos - 1) * k + 2, last = first + k - 1
   assign pm1 = HANDLE_BITS'(alu_i.pos - COUNT_BITS'(1));
   assign ci  = CHILD_BITS'(pm1) * CHILD_BITS'(alu_i.k) + CHILD_BITS'(2);
   assign alu_o.ci   = ci;
   assign alu_o.last = ci + CHILD_BITS'(alu_i.k) - CHILD_BITS'(1);

   // signed compare
   assign alu_o.a_gt_b = $signed(alu_i.key_a) > $signed(alu_i.key_b);

endmodule

[rtl/d_ary_min_heap_priority_queue_core.sv]
// Top level: addressable d-ary min-heap with sequencer, memories and free list.
//
// Usage: drive req_* and raise start; the command transfers at a rising edge with
// start high and busy low. busy stays high until the result is shown. Each result
// is on the rsp_* ports for one cycle with rsp_valid high; the receiver cannot
// stall it, so it must take it in that cycle.
// Registers (arity, capacity_limit) are written on the csr_ channel; csr_ready is
// always high, and writes are meant only while the block is idle.
// Each command runs dispatch, its own steps and a finishing read of the root, with one
// shared index/compare unit and one read port per memory: insert (rising up to 8
// levels) and decrease rise level by level; delete of the last entry needs no repair,
// other deletes sink, scanning up to k children per level, or rise.
// One command at a time; the next may transfer once busy drops.
// Reset: heap empty, handles free in ascending order, arity 2, limit 256.
// Heap and per-handle stores need no clearing pass; handle valid bits and the
// free-list written bits are flip-flops cleared at once by reset and by clear.
module d_ary_min_heap_priority_queue_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_kind,
   input  logic [dahp_pkg::HANDLE_BITS-1:0]  req_handle_in,
   input  logic signed [dahp_pkg::KEY_BITS-1:0] req_key_in,
   input  logic [dahp_pkg::INFO_BITS-1:0]    req_info_in,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [dahp_pkg::HANDLE_BITS-1:0]  rsp_handle_out,
   output logic                              rsp_empty_res,
   output logic [dahp_pkg::HANDLE_BITS-1:0]  rsp_min_handle,
   output logic signed [dahp_pkg::KEY_BITS-1:0] rsp_min_key,
   output logic [dahp_pkg::INFO_BITS-1:0]    rsp_min_info,
   output logic [dahp_pkg::COUNT_BITS-1:0]   rsp_entry_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dahp_pkg::INDEX_BITS-1:0]   csr_index,
   input  logic [dahp_pkg::COUNT_BITS-1:0]   csr_data
);
   import dahp_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISP = 4'd1;
   localparam logic [3:0] S_INS  = 4'd2;
   localparam logic [3:0] S_DEC1 = 4'd3;
   localparam logic [3:0] S_DEC2 = 4'd4;
   localparam logic [3:0] S_DEL1 = 4'd5;
   localparam logic [3:0] S_DEL2 = 4'd6;
   localparam logic [3:0] S_R0   = 4'd7;
   localparam logic [3:0] S_R1   = 4'd8;
   localparam logic [3:0] S_S0   = 4'd9;
   localparam logic [3:0] S_S1   = 4'd10;
   localparam logic [3:0] S_S2   = 4'd11;
   localparam logic [3:0] S_FIN  = 4'd12;
   localparam logic [3:0] S_F1   = 4'd13;
   localparam logic [3:0] S_F2   = 4'd14;

   localparam logic [COUNT_BITS-1:0] CAP_CNT = COUNT_BITS'(CAPACITY);

   // control state
   logic [3:0]              state_ff, state_in;
   logic [COUNT_BITS-1:0]   fill_ff, fill_in, ftop_ff, ftop_in;
   logic [ARITY_BITS-1:0]   arity_ff, arity_in;
   logic [COUNT_BITS-1:0]   limit_ff, limit_in;
   logic [CAPACITY-1:0]     valid_ff, valid_in, fsv_ff, fsv_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload / work registers
   logic [2:0]              kind_ff, kind_in;
   logic [HANDLE_BITS-1:0]  hin_ff, hin_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [INFO_BITS-1:0]    info_ff, info_in;
   logic [COUNT_BITS-1:0]   pos_ff, pos_in, par_ff, par_in;
   logic [COUNT_BITS-1:0]   last_ff, last_in, j_ff, j_in, best_pos_ff, best_pos_in;
   entry_type               mv_ff, mv_in, best_ff, best_in, root_ff, root_in;
   logic [1:0]              status_ff, status_in;
   logic [HANDLE_BITS-1:0]  hout_ff, hout_in;
   logic [1:0]              o_status_ff, o_status_in;
   logic [HANDLE_BITS-1:0]  o_hout_ff, o_hout_in, o_mh_ff, o_mh_in;
   logic                    o_empty_ff, o_empty_in;
   logic [KEY_BITS-1:0]     o_mk_ff, o_mk_in;
   logic [INFO_BITS-1:0]    o_mi_ff, o_mi_in;
   logic [COUNT_BITS-1:0]   o_cnt_ff, o_cnt_in;

   // memories and their ports
   entry_type               heap_mem [CAPACITY];
   logic [HANDLE_BITS-1:0]  slot_mem [CAPACITY];
   logic [INFO_BITS-1:0]    info_mem [CAPACITY];
   logic [HANDLE_BITS-1:0]  free_mem [CAPACITY];
   entry_type               heap_rd_ff, heap_wd;
   logic [HANDLE_BITS-1:0]  slot_rd_ff, free_rd_ff, slot_wd, free_wd;
   logic [INFO_BITS-1:0]    info_rd_ff, info_wd;
   logic [HANDLE_BITS-1:0]  heap_ra, heap_wa, slot_ra, slot_wa;
   logic [HANDLE_BITS-1:0]  info_ra, info_wa, free_ra, free_wa;
   logic                    heap_we, slot_we, info_we, free_we;

   alu_in_type              alu_i;
   alu_out_type             alu_o;
   logic [ARITY_BITS-1:0]   eff_k;
   logic [COUNT_BITS-1:0]   eff_lim;
   logic                    live;
   logic [HANDLE_BITS-1:0]  new_h;
   logic [HANDLE_BITS-1:0]  pos_m1;
   logic [HANDLE_BITS-1:0]  ftop_m1;

   dahp_alu u_alu (.alu_i(alu_i), .alu_o(alu_o));

   assign eff_k   = (arity_ff < ARITY_BITS'(2)) ? ARITY_BITS'(2) :
                    (arity_ff > ARITY_BITS'(MAX_ARITY)) ? ARITY_BITS'(MAX_ARITY) : arity_ff;
   assign eff_lim = (limit_ff > CAP_CNT) ? CAP_CNT : limit_ff;
   assign live    = valid_ff[hin_ff];
   assign new_h   = fsv_ff[ftop_ff[HANDLE_BITS-1:0]] ? free_rd_ff : ftop_ff[HANDLE_BITS-1:0];
   assign pos_m1  = HANDLE_BITS'(pos_ff - COUNT_BITS'(1));
   assign ftop_m1 = HANDLE_BITS'(ftop_ff - COUNT_BITS'(1));

   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = o_status_ff;
   assign rsp_handle_out  = o_hout_ff;
   assign rsp_empty_res   = o_empty_ff;
   assign rsp_min_handle  = o_mh_ff;
   assign rsp_min_key     = o_mk_ff;
   assign rsp_min_info    = o_mi_ff;
   assign rsp_entry_count = o_cnt_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;   fill_in = fill_ff;     ftop_in = ftop_ff;
      arity_in = arity_ff;   limit_in = limit_ff;   valid_in = valid_ff;
      fsv_in = fsv_ff;       rsp_valid_in = 1'b0;
      kind_in = kind_ff;     hin_in = hin_ff;       key_in = key_ff;   info_in = info_ff;
      pos_in = pos_ff;       par_in = par_ff;       last_in = last_ff; j_in = j_ff;
      best_pos_in = best_pos_ff; mv_in = mv_ff;     best_in = best_ff; root_in = root_ff;
      status_in = status_ff; hout_in = hout_ff;
      o_status_in = o_status_ff; o_hout_in = o_hout_ff; o_mh_in = o_mh_ff;
      o_empty_in = o_empty_ff;   o_mk_in = o_mk_ff;     o_mi_in = o_mi_ff;
      o_cnt_in = o_cnt_ff;
      heap_we = 1'b0; heap_wa = pos_m1;   heap_wd = mv_ff;    heap_ra = '0;
      slot_we = 1'b0; slot_wa = mv_ff.hdl; slot_wd = pos_m1;  slot_ra = hin_ff;
      info_we = 1'b0; info_wa = hin_ff;   info_wd = info_ff;  info_ra = heap_rd_ff.hdl;
      free_we = 1'b0; free_wa = ftop_m1;  free_wd = hin_ff;   free_ra = ftop_ff[HANDLE_BITS-1:0];
      alu_i.pos = pos_ff; alu_i.k = eff_k; alu_i.key_a = mv_ff.key; alu_i.key_b = heap_rd_ff.key;

      // register writes
      if (csr_valid) begin
         if (csr_index == REG_ARITY) arity_in = csr_data[ARITY_BITS-1:0];
         else if (csr_index == REG_LIMIT) limit_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind; hin_in = req_handle_in;
               key_in = req_key_in; info_in = req_info_in;
               status_in = STATUS_OK; hout_in = req_handle_in;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_FIN;
            case (kind_ff)
               KIND_INSERT: begin
                  if (fill_ff >= eff_lim || ftop_ff >= CAP_CNT) status_in = STATUS_OVERFLOW;
                  else state_in = S_INS;
               end
               KIND_DECREASE: begin
                  if (!live) status_in = STATUS_BAD_HDL;
                  else state_in = S_DEC1;
               end
               KIND_DELETE: begin
                  heap_ra = HANDLE_BITS'(fill_ff - COUNT_BITS'(1));
                  if (!live) status_in = STATUS_BAD_HDL;
                  else state_in = S_DEL1;
               end
               KIND_INFO: begin
                  if (!live) status_in = STATUS_BAD_HDL;
                  else info_we = 1'b1;
               end
               KIND_CLEAR: begin
                  valid_in = '0; fsv_in = '0; ftop_in = '0; fill_in = '0;
               end
               default: ;
            endcase
         end
         S_INS: begin
            mv_in.hdl = new_h; mv_in.key = key_ff; hout_in = new_h;
            info_we = 1'b1; info_wa = new_h;
            valid_in[new_h] = 1'b1;
            ftop_in = ftop_ff + COUNT_BITS'(1);
            fill_in = fill_ff + COUNT_BITS'(1);
            pos_in  = fill_ff + COUNT_BITS'(1);
            state_in = S_R0;
         end
         S_DEC1: begin
            heap_ra = slot_rd_ff;
            pos_in = COUNT_BITS'(slot_rd_ff) + COUNT_BITS'(1);
            state_in = S_DEC2;
         end
         S_DEC2: begin
            alu_i.key_a = key_ff;
            if (alu_o.a_gt_b) begin
               status_in = STATUS_KEY_UP; state_in = S_FIN;
            end else begin
               mv_in.hdl = hin_ff; mv_in.key = key_ff; state_in = S_R0;
            end
         end
         S_DEL1: begin
            heap_ra = slot_rd_ff;
            pos_in = COUNT_BITS'(slot_rd_ff) + COUNT_BITS'(1);
            mv_in = heap_rd_ff;
            fill_in = fill_ff - COUNT_BITS'(1);
            valid_in[hin_ff] = 1'b0;
            if (ftop_ff != '0) begin
               ftop_in = ftop_ff - COUNT_BITS'(1);
               free_we = 1'b1;
               fsv_in[ftop_m1] = 1'b1;
            end
            state_in = S_DEL2;
         end
         S_DEL2: begin
            // removed key is in heap_rd_ff
            if (mv_ff.hdl == hin_ff) state_in = S_FIN;
            else if (alu_o.a_gt_b) state_in = S_S0;
            else state_in = S_R0;
         end
         S_R0: begin
            if (pos_ff == COUNT_BITS'(1)) begin
               heap_we = 1'b1; slot_we = 1'b1; state_in = S_FIN;
            end else begin
               heap_ra = HANDLE_BITS'(alu_o.par - COUNT_BITS'(1));
               par_in = alu_o.par;
               state_in = S_R1;
            end
         end
         S_R1: begin
            alu_i.key_a = heap_rd_ff.key; alu_i.key_b = mv_ff.key;
            heap_we = 1'b1; slot_we = 1'b1;
            if (alu_o.a_gt_b) begin
               // parent moves down one level
               heap_wd = heap_rd_ff; slot_wa = heap_rd_ff.hdl;
               pos_in = par_ff; state_in = S_R0;
            end else begin
               state_in = S_FIN;
            end
         end
         S_S0: begin
            if (alu_o.ci > CHILD_BITS'(fill_ff)) begin
               heap_we = 1'b1; slot_we = 1'b1; state_in = S_FIN;
            end else begin
               last_in = (alu_o.last > CHILD_BITS'(fill_ff)) ? fill_ff :
                         COUNT_BITS'(alu_o.last);
               j_in = COUNT_BITS'(alu_o.ci);
               best_pos_in = COUNT_BITS'(alu_o.ci);
               heap_ra = HANDLE_BITS'(alu_o.ci - CHILD_BITS'(1));
               state_in = S_S1;
            end
         end
         S_S1: begin
            // scan children, keeping the first smallest
            alu_i.key_a = best_ff.key; alu_i.key_b = heap_rd_ff.key;
            if (j_ff == best_pos_ff || alu_o.a_gt_b) begin
               best_in = heap_rd_ff; best_pos_in = j_ff;
            end
            if (j_ff < last_ff) begin
               j_in = j_ff + COUNT_BITS'(1);
               heap_ra = j_ff[HANDLE_BITS-1:0];
            end else begin
               state_in = S_S2;
            end
         end
         S_S2: begin
            alu_i.key_b = best_ff.key;
            heap_we = 1'b1; slot_we = 1'b1;
            if (alu_o.a_gt_b) begin
               heap_wd = best_ff; slot_wa = best_ff.hdl;
               pos_in = best_pos_ff; state_in = S_S0;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            heap_ra = '0; state_in = S_F1;
         end
         S_F1: begin
            root_in = heap_rd_ff; state_in = S_F2;
         end
         S_F2: begin
            o_status_in = status_ff; o_hout_in = hout_ff;
            o_cnt_in = fill_ff; o_empty_in = fill_ff == '0;
            o_mh_in = (fill_ff == '0) ? '0 : root_ff.hdl;
            o_mk_in = (fill_ff == '0) ? '0 : root_ff.key;
            o_mi_in = (fill_ff == '0) ? '0 : info_rd_ff;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fill_ff <= '0; ftop_ff <= '0;
         arity_ff <= ARITY_BITS'(2); limit_ff <= CAP_CNT;
         valid_ff <= '0; fsv_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; ftop_ff <= ftop_in;
         arity_ff <= arity_in; limit_ff <= limit_in;
         valid_ff <= valid_in; fsv_ff <= fsv_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in; hin_ff <= hin_in; key_ff <= key_in; info_ff <= info_in;
      pos_ff <= pos_in; par_ff <= par_in; last_ff <= last_in; j_ff <= j_in;
      best_pos_ff <= best_pos_in; mv_ff <= mv_in; best_ff <= best_in; root_ff <= root_in;
      status_ff <= status_in; hout_ff <= hout_in;
      o_status_ff <= o_status_in; o_hout_ff <= o_hout_in; o_mh_ff <= o_mh_in;
      o_empty_ff <= o_empty_in; o_mk_ff <= o_mk_in; o_mi_ff <= o_mi_in; o_cnt_ff <= o_cnt_in;
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[heap_wa] <= heap_wd;
      heap_rd_ff <= heap_mem[heap_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      slot_rd_ff <= slot_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (info_we) info_mem[info_wa] <= info_wd;
      info_rd_ff <= info_mem[info_ra];
   end

   always_ff @(posedge clock) begin
      if (free_we) free_mem[free_wa] <= free_wd;
      free_rd_ff <= free_mem[free_ra];
   end

endmodule

[rtl/dahp_checker.sv]
// Port-level checker for the heap core, bound to the top level.
module dahp_port_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic                              rsp_empty_res,
   input logic [dahp_pkg::HANDLE_BITS-1:0]  rsp_min_handle,
   input logic [dahp_pkg::COUNT_BITS-1:0]   rsp_entry_count
);
   import dahp_pkg::*;

   // a command transfer makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after command transfer");

   // result strobe lasts one cycle
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // result is shown only once the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // empty flag agrees with count, and an empty heap shows a zero root
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_res == (rsp_entry_count == '0)) &&
                    (!rsp_empty_res || rsp_min_handle == '0))
      else $error("empty flag inconsistent with count or root");

endmodule

bind d_ary_min_heap_priority_queue_core dahp_port_checker u_dahp_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_empty_res(rsp_empty_res),
   .rsp_min_handle(rsp_min_handle), .rsp_entry_count(rsp_entry_count)
);

[test/dahp_checker.sv]
// Checker for the d-ary heap core: predicts every command's result and compares it.
module dahp_checker
   import dahp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [2:0]                  req_kind,
   input  logic [HANDLE_BITS-1:0]      req_handle_in,
   input  logic signed [KEY_BITS-1:0]  req_key_in,
   input  logic [INFO_BITS-1:0]        req_info_in,
   input  logic                        rsp_valid,
   input  logic [1:0]                  rsp_status,
   input  logic [HANDLE_BITS-1:0]      rsp_handle_out,
   input  logic                        rsp_empty_res,
   input  logic [HANDLE_BITS-1:0]      rsp_min_handle,
   input  logic signed [KEY_BITS-1:0]  rsp_min_key,
   input  logic [INFO_BITS-1:0]        rsp_min_info,
   input  logic [COUNT_BITS-1:0]       rsp_entry_count,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [INDEX_BITS-1:0]       csr_index,
   input  logic [COUNT_BITS-1:0]       csr_data,
   output int                          fails,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]                 status;
      logic [HANDLE_BITS-1:0]     hout;
      logic                       empty;
      logic [HANDLE_BITS-1:0]     min_hdl;
      logic signed [KEY_BITS-1:0] min_key;
      logic [INFO_BITS-1:0]       min_info;
      logic [COUNT_BITS-1:0]      count;
   } heap_result_t;

   heap_result_t result_q[$];

   // shadow heap
   logic [HANDLE_BITS-1:0]     slot_hdl[1:CAPACITY];
   logic signed [KEY_BITS-1:0] hkey[CAPACITY];
   logic [INFO_BITS-1:0]       hinfo[CAPACITY];
   int                         hpos[CAPACITY];
   bit                         hlive[CAPACITY];
   logic [HANDLE_BITS-1:0]     free_list[CAPACITY];
   int                         free_ptr;
   int                         fill;
   logic [ARITY_BITS-1:0]      arity_reg;
   logic [COUNT_BITS-1:0]      limit_reg;

   function automatic int eff_k();
      if (arity_reg < 2) return 2;
      if (arity_reg > MAX_ARITY) return MAX_ARITY;
      return arity_reg;
   endfunction

   function automatic void put(int pos, logic [HANDLE_BITS-1:0] h);
      slot_hdl[pos] = h;
      hpos[h] = pos;
   endfunction

   function automatic void heap_rise(int pos, logic [HANDLE_BITS-1:0] h);
      int k;
      int par;
      k = eff_k();
      while (pos > 1) begin
         par = (k + pos - 2) / k;
         if (hkey[slot_hdl[par]] > hkey[h]) begin
            put(pos, slot_hdl[par]);
            pos = par;
         end else break;
      end
      put(pos, h);
   endfunction

   function automatic void heap_sink(int pos, logic [HANDLE_BITS-1:0] h);
      int k;
      int ci;
      int last;
      int best;
      k = eff_k();
      forever begin
         ci = (pos - 1) * k + 2;
         if (ci > fill) break;
         last = ci + k - 1;
         if (last > fill) last = fill;
         best = ci;
         for (int j = ci + 1; j <= last; j++)
            if (hkey[slot_hdl[j]] < hkey[slot_hdl[best]]) best = j;
         if (hkey[h] <= hkey[slot_hdl[best]]) break;
         put(pos, slot_hdl[best]);
         pos = best;
      end
      put(pos, h);
   endfunction

   function automatic void free_all();
      for (int i = 0; i < CAPACITY; i++) begin
         free_list[i] = i[HANDLE_BITS-1:0];
         hlive[i] = 1'b0;
      end
      free_ptr = 0;
      fill = 0;
   endfunction

   // apply one command to the shadow heap and return the root view after it
   function automatic heap_result_t heap_apply(logic [2:0] kind, logic [HANDLE_BITS-1:0] hin,
                                               logic signed [KEY_BITS-1:0] key,
                                               logic [INFO_BITS-1:0] info);
      heap_result_t r;
      logic [HANDLE_BITS-1:0] h;
      logic [HANDLE_BITS-1:0] lh;
      int lim;
      int pos;
      r.status = STATUS_OK;
      r.hout = hin;
      lim = (limit_reg > CAPACITY) ? CAPACITY : limit_reg;
      case (kind)
         KIND_INSERT: begin
            if (fill >= lim || free_ptr >= CAPACITY) r.status = STATUS_OVERFLOW;
            else begin
               h = free_list[free_ptr];
               free_ptr++;
               fill++;
               hkey[h] = key;
               hinfo[h] = info;
               hlive[h] = 1'b1;
               heap_rise(fill, h);
               r.hout = h;
            end
         end
         KIND_DECREASE: begin
            if (!hlive[hin]) r.status = STATUS_BAD_HDL;
            else if (key > hkey[hin]) r.status = STATUS_KEY_UP;
            else begin
               hkey[hin] = key;
               heap_rise(hpos[hin], hin);
            end
         end
         KIND_DELETE: begin
            if (!hlive[hin]) r.status = STATUS_BAD_HDL;
            else begin
               pos = hpos[hin];
               lh = slot_hdl[fill];
               fill--;
               if (lh != hin) begin
                  if (hkey[lh] > hkey[hin]) heap_sink(pos, lh);
                  else heap_rise(pos, lh);
               end
               hlive[hin] = 1'b0;
               if (free_ptr > 0) begin
                  free_ptr--;
                  free_list[free_ptr] = hin;
               end
            end
         end
         KIND_INFO: begin
            if (!hlive[hin]) r.status = STATUS_BAD_HDL;
            else hinfo[hin] = info;
         end
         KIND_CLEAR: free_all();
         default: ;
      endcase
      r.empty = (fill == 0);
      r.count = fill[COUNT_BITS-1:0];
      if (fill > 0) begin
         r.min_hdl = slot_hdl[1];
         r.min_key = hkey[slot_hdl[1]];
         r.min_info = hinfo[slot_hdl[1]];
      end else begin
         r.min_hdl = '0;
         r.min_key = '0;
         r.min_info = '0;
      end
      return r;
   endfunction

   // compare results, track register writes, predict each command transfer
   always @(posedge clock) begin
      heap_result_t e;
      if (reset) begin
         free_all();
         arity_reg <= 4'd2;
         limit_reg <= 9'd256;
         result_q.delete();
      end else begin
         if (rsp_valid) begin
            if (result_q.size() == 0) begin
               $error("result with nothing expected");
               fails++;
            end else begin
               e = result_q.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status exp %0h got %0h", e.status, rsp_status);
                  fails++;
               end
               if (rsp_handle_out !== e.hout) begin
                  $error("handle_out exp %0h got %0h", e.hout, rsp_handle_out);
                  fails++;
               end
               if (rsp_empty_res !== e.empty) begin
                  $error("empty_res exp %0h got %0h", e.empty, rsp_empty_res);
                  fails++;
               end
               if (rsp_min_handle !== e.min_hdl) begin
                  $error("min_handle exp %0h got %0h", e.min_hdl, rsp_min_handle);
                  fails++;
               end
               if (rsp_min_key !== e.min_key) begin
                  $error("min_key exp %0h got %0h", e.min_key, rsp_min_key);
                  fails++;
               end
               if (rsp_min_info !== e.min_info) begin
                  $error("min_info exp %0h got %0h", e.min_info, rsp_min_info);
                  fails++;
               end
               if (rsp_entry_count !== e.count) begin
                  $error("entry_count exp %0h got %0h", e.count, rsp_entry_count);
                  fails++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ARITY) arity_reg <= csr_data[ARITY_BITS-1:0];
            else if (csr_index == REG_LIMIT) limit_reg <= csr_data;
         end
         if (start && !busy)
            result_q.push_back(heap_apply(req_kind, req_handle_in, req_key_in, req_info_in));
      end
      pending <= result_q.size();
   end

   initial begin
      fails = 0;
      pending = 0;
   end

endmodule

[test/d_ary_min_heap_priority_queue_core_tb.sv]
// Testbench top: clock, reset, command and register stimulus, verdict.
module d_ary_min_heap_priority_queue_core_tb;
   import dahp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [2:0]                 req_kind;
   logic [HANDLE_BITS-1:0]     req_handle_in;
   logic signed [KEY_BITS-1:0] req_key_in;
   logic [INFO_BITS-1:0]       req_info_in;
   logic                       rsp_valid;
   logic [1:0]                 rsp_status;
   logic [HANDLE_BITS-1:0]     rsp_handle_out;
   logic                       rsp_empty_res;
   logic [HANDLE_BITS-1:0]     rsp_min_handle;
   logic signed [KEY_BITS-1:0] rsp_min_key;
   logic [INFO_BITS-1:0]       rsp_min_info;
   logic [COUNT_BITS-1:0]      rsp_entry_count;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [INDEX_BITS-1:0]      csr_index;
   logic [COUNT_BITS-1:0]      csr_data;
   int                         fails;
   int                         pending;
   int                         quiet_cycles;

   localparam logic [2:0] KIND_SPARE = 3'd5;
   localparam int STALL_LIMIT = 5000;

   d_ary_min_heap_priority_queue_core dut (.*);

   dahp_checker chk (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   // one command transfer; called and returns at a falling edge
   task automatic send(logic [2:0] kind, logic [HANDLE_BITS-1:0] h,
                       logic signed [KEY_BITS-1:0] key, logic [INFO_BITS-1:0] info);
      start <= 1'b1;
      req_kind <= kind;
      req_handle_in <= h;
      req_key_in <= key;
      req_info_in <= info;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic idle(int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      idle(1);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [INDEX_BITS-1:0] idx, logic [COUNT_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 16)) - 8;
         2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom_range(0, 100);
      endcase
   endfunction

   // random commands of every kind; handles mostly up to hmax, sometimes any
   task automatic run_phase(int n, int idle_pct, int ins_pct, int hmax, bit hold_once);
      int r;
      logic [2:0] kind;
      logic [HANDLE_BITS-1:0] h;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < ins_pct) kind = KIND_INSERT;
         else if (r < ins_pct + (100 - ins_pct) * 4 / 10) kind = KIND_DELETE;
         else if (r < ins_pct + (100 - ins_pct) * 7 / 10) kind = KIND_DECREASE;
         else if (r < 97) kind = KIND_INFO;
         else if (r < 98) kind = KIND_CLEAR;
         else kind = 3'($urandom_range(KIND_SPARE, 7));
         h = ($urandom_range(0, 9) == 0) ? HANDLE_BITS'($urandom_range(0, 255)) :
                                           HANDLE_BITS'($urandom_range(0, hmax));
         send(kind, h, pick_key(), $urandom);
         if (hold_once && i == n / 2) drain();
         if ($urandom_range(0, 99) < idle_pct) idle($urandom_range(1, 4));
      end
   endtask

   task automatic phase(int k, int lim, int n, int idle_pct, int ins_pct, int hmax,
                        bit hold_once);
      drain();
      csr_write(REG_ARITY, COUNT_BITS'(k));
      csr_write(REG_LIMIT, COUNT_BITS'(lim));
      run_phase(n, idle_pct, ins_pct, hmax, hold_once);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_INSERT;
      req_handle_in = '0;
      req_key_in = '0;
      req_info_in = '0;
      csr_valid = 1'b0;
      csr_index = REG_ARITY;
      csr_data = '0;
      quiet_cycles = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: key extremes, ties, rejects, spare kinds, clear
      send(KIND_INSERT, 8'd0, 32'sh7fffffff, 32'hffffffff);
      send(KIND_INSERT, 8'd0, 32'sh80000000, 32'h0);
      send(KIND_INSERT, 8'd0, 32'sd0, 32'h1234);
      send(KIND_INSERT, 8'd0, 32'sd5, 32'h55);
      send(KIND_INSERT, 8'hff, 32'sd5, 32'h66);
      send(KIND_DECREASE, 8'd3, 32'sd5, 32'h0);
      send(KIND_DECREASE, 8'd2, 32'sd1, 32'h0);
      send(KIND_DECREASE, 8'd0, 32'sh80000000, 32'h0);
      send(KIND_DELETE, 8'd1, 32'sd0, 32'h0);
      send(KIND_DELETE, 8'd4, 32'sd0, 32'h0);
      send(KIND_DELETE, 8'hff, 32'sd0, 32'h0);
      send(KIND_DELETE, 8'd1, 32'sd0, 32'h0);
      send(KIND_INFO, 8'd0, 32'sd0, 32'hdeadbeef);
      send(KIND_INFO, 8'd200, 32'sd0, 32'h1);
      send(KIND_DECREASE, 8'd77, 32'sd0, 32'h0);
      send(KIND_SPARE, 8'd0, 32'sd0, 32'h0);
      send(3'd6, 8'd0, 32'sd0, 32'h0);
      send(3'd7, 8'd0, 32'sd0, 32'h0);
      send(KIND_INSERT, 8'd0, 32'sd3, 32'h3);
      send(KIND_CLEAR, 8'd0, 32'sd0, 32'h0);
      send(KIND_INSERT, 8'd9, 32'sd9, 32'h9);
      send(KIND_INSERT, 8'd0, 32'sd4, 32'h4);
      send(KIND_DELETE, 8'd1, 32'sd0, 32'h0);
      send(KIND_DELETE, 8'd0, 32'sd0, 32'h0);

      // random phases over register settings, extremes included
      phase(8, 256, 320, 0, 85, 255, 1'b0);
      phase(2, 256, 250, 54, 40, 63, 1'b0);
      phase(3, 1, 250, 35, 40, 7, 1'b0);
      phase(5, 17, 250, 0, 45, 31, 1'b1);
      phase(4, 200, 250, 54, 40, 255, 1'b0);

      drain();
      repeat (100) @(negedge clock);
      if (fails == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
